### rtl/rhg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// RTP header generator package
// Shared types, register reset values and field widths.
// ----------------------------------------------------------------------------
package rhg_pkg;

    localparam int unsigned TICK_FREQ_DEF   = 27000000;
    localparam int unsigned QUEUE_DEPTH_DEF = 4;

    localparam int unsigned TIME_W   = 64;
    localparam int unsigned WORD_W   = 32;
    localparam int unsigned SEQ_W    = 16;
    localparam int unsigned PT_W     = 7;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_SYNC = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PT   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MPA  = 2'd3;

    localparam logic              SYNC_RST = 1'b1;
    localparam logic [WORD_W-1:0] RATE_RST = 32'd90000;
    localparam logic [PT_W-1:0]   PT_RST   = 7'd96;
    localparam logic              MPA_RST  = 1'b0;

    localparam logic [1:0] RTP_VERSION = 2'd2;

    typedef struct packed {
        logic              sync_to_clock_ref;
        logic [WORD_W-1:0] rtp_clock_rate;
        logic [PT_W-1:0]   payload_type;
        logic              mpa_header_enable;
    } t_cfg;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

endpackage
`default_nettype wire

### rtl/rtp_header_generator_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// RTP header generator
// Turns packet descriptors into 12-byte (or 16-byte) RTP headers.
//
// Input channel: one packet descriptor per item (i_in_valid / o_in_stall).
// Output channel: one 32-bit header word per item (o_out_valid / i_out_stall),
// o_last_word set on the final word of a packet. Words: header, timestamp,
// SSRC, and a zero MPEG audio word when that mode is on.
// Configuration: write-only port, i_cfg_index selects the register; write it
// only while no packet is in flight.
// Path: a descriptor passes the rescale pipeline (two four-stage reciprocal
// dividers, a multiply stage and a sum stage), then the queue and the output
// word register before the first word of its packet is presented.
// Throughput: the output register issues one word per cycle while the queue
// is not empty and the receiver does not stall.
// A stalled receiver holds the output word; the 4-entry timestamp queue
// then fills and the input is stalled, which freezes the whole pipeline.
// Reset restores the register defaults and clears the sequence number.
// ----------------------------------------------------------------------------
module rtp_header_generator_unit
    import rhg_pkg::*;
#(
    parameter int unsigned TICK_FREQ   = TICK_FREQ_DEF,
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic                 i_pts_prog_valid,
    input  wire logic [TIME_W-1:0]    i_pts_prog_time,
    input  wire logic                 i_pts_sys_valid,
    input  wire logic [TIME_W-1:0]    i_pts_sys_time,
    input  wire logic                 i_cr_prog_valid,
    input  wire logic [TIME_W-1:0]    i_cr_prog_time,
    input  wire logic                 i_cr_sys_valid,
    input  wire logic [TIME_W-1:0]    i_cr_sys_time,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic [WORD_W-1:0]         o_header_word,
    output logic                      o_last_word,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [WORD_W-1:0]    i_cfg_data
);

    t_cfg              r_cfg;
    logic              w_en;
    logic              w_fr_vld;
    logic [WORD_W-1:0] w_fr_ts;
    logic              w_push;
    logic              w_pop;
    logic [WORD_W-1:0] w_q_data;
    t_q_stat           w_q_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_to_clock_ref <= SYNC_RST;
            r_cfg.rtp_clock_rate    <= RATE_RST;
            r_cfg.payload_type      <= PT_RST;
            r_cfg.mpa_header_enable <= MPA_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SYNC: r_cfg.sync_to_clock_ref <= i_cfg_data[0];
                CFG_RATE: r_cfg.rtp_clock_rate    <= i_cfg_data;
                CFG_PT:   r_cfg.payload_type      <= i_cfg_data[PT_W-1:0];
                CFG_MPA:  r_cfg.mpa_header_enable <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // pipeline moves unless its last stage is blocked by a full queue
    assign w_en       = !(w_fr_vld && w_q_stat.full);
    assign w_push     = w_fr_vld && !w_q_stat.full;
    assign o_in_stall = !w_en;

    rhg_front #(
        .TICK_FREQ (TICK_FREQ)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_en             (w_en),
        .i_valid          (i_in_valid),
        .i_pts_prog_valid (i_pts_prog_valid),
        .i_pts_prog_time  (i_pts_prog_time),
        .i_pts_sys_valid  (i_pts_sys_valid),
        .i_pts_sys_time   (i_pts_sys_time),
        .i_cr_prog_valid  (i_cr_prog_valid),
        .i_cr_prog_time   (i_cr_prog_time),
        .i_cr_sys_valid   (i_cr_sys_valid),
        .i_cr_sys_time    (i_cr_sys_time),
        .i_cfg            (r_cfg),
        .o_valid          (w_fr_vld),
        .o_ts             (w_fr_ts)
    );

    rhg_queue #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (WORD_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_fr_ts),
        .i_pop   (w_pop),
        .o_data  (w_q_data),
        .o_stat  (w_q_stat)
    );

    rhg_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_q_data (w_q_data),
        .i_q_stat (w_q_stat),
        .o_pop    (w_pop),
        .o_valid  (o_out_valid),
        .o_word   (o_header_word),
        .o_last   (o_last_word),
        .i_stall  (i_out_stall)
    );

`ifndef SYNTHESIS
    a_hdr_after_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_last_word) |=>
        (!o_out_valid || (o_header_word[31:23] == 9'h100)))
        else $error("word after end of packet is not a header word");

    a_packet_continues : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_last_word) |=> o_out_valid)
        else $error("packet words interrupted");

    a_queue_state : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_q_stat.full && w_q_stat.empty))
        else $error("queue full and empty at once");
`endif

endmodule
`default_nettype wire

### rtl/rhg_cdiv.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Constant divisor pipeline
// Divides a 64-bit number by a fixed divisor in four stages: reciprocal
// multiply, quotient estimate, remainder, one correction step. The quotient
// is kept modulo 2^32; a side word is carried alongside.
// ----------------------------------------------------------------------------
module rhg_cdiv
    import rhg_pkg::*;
#(
    parameter int unsigned DIVISOR = TICK_FREQ_DEF,
    parameter int unsigned RW      = $clog2(DIVISOR),
    parameter int unsigned SW      = 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire logic [TIME_W-1:0] i_num,
    input  wire logic [SW-1:0]     i_side,
    output logic                   o_valid,
    output logic [WORD_W-1:0]      o_quot,
    output logic [RW-1:0]          o_rem,
    output logic [SW-1:0]          o_side
);

    // floor((2^64 - 1) / D) leaves the estimate at most one below the quotient
    localparam logic [TIME_W-1:0] RECIP    = {TIME_W{1'b1}} / TIME_W'(DIVISOR);
    localparam logic [WORD_W-1:0] RECIP_HI = RECIP[TIME_W-1:WORD_W];
    localparam logic [WORD_W-1:0] RECIP_LO = RECIP[WORD_W-1:0];
    localparam logic [WORD_W-1:0] DIV_W    = WORD_W'(DIVISOR);

    logic [WORD_W-1:0] w_num_hi;
    logic [WORD_W-1:0] w_num_lo;
    logic [WORD_W-1:0] n_s1_hh;
    logic [TIME_W-1:0] n_s1_hl;
    logic [TIME_W-1:0] n_s1_lh;
    logic [TIME_W-1:0] n_s1_ll;
    logic              r_s1_vld;
    logic [WORD_W-1:0] r_s1_hh;
    logic [TIME_W-1:0] r_s1_hl;
    logic [TIME_W-1:0] r_s1_lh;
    logic [WORD_W-1:0] r_s1_ll;
    logic [WORD_W-1:0] r_s1_lo;
    logic [SW-1:0]     r_s1_side;
    logic [TIME_W-1:0] n_s2_mid;
    logic [WORD_W-1:0] n_s2_qest;
    logic              r_s2_vld;
    logic [WORD_W-1:0] r_s2_qest;
    logic [WORD_W-1:0] r_s2_lo;
    logic [SW-1:0]     r_s2_side;
    logic [WORD_W-1:0] n_s3_rest;
    logic              r_s3_vld;
    logic [WORD_W-1:0] r_s3_qest;
    logic [WORD_W-1:0] r_s3_rest;
    logic [SW-1:0]     r_s3_side;
    logic              w_take;
    logic [WORD_W-1:0] n_s4_quot;
    logic [WORD_W-1:0] n_s4_rem;
    logic              r_s4_vld;
    logic [WORD_W-1:0] r_s4_quot;
    logic [RW-1:0]     r_s4_rem;
    logic [SW-1:0]     r_s4_side;

    assign w_num_hi = i_num[TIME_W-1:WORD_W];
    assign w_num_lo = i_num[WORD_W-1:0];

    // partial products of num * RECIP, 32 x 32 each
    assign n_s1_hh = WORD_W'(w_num_hi * RECIP_HI);
    assign n_s1_hl = TIME_W'(w_num_hi) * TIME_W'(RECIP_LO);
    assign n_s1_lh = TIME_W'(w_num_lo) * TIME_W'(RECIP_HI);
    assign n_s1_ll = TIME_W'(w_num_lo) * TIME_W'(RECIP_LO);

    // bits 95:64 of the full product
    assign n_s2_mid  = r_s1_hl + r_s1_lh + TIME_W'(r_s1_ll);
    assign n_s2_qest = r_s1_hh + n_s2_mid[TIME_W-1:WORD_W];

    // true remainder is below 2 * D, so the low word is exact
    assign n_s3_rest = r_s2_lo - WORD_W'(r_s2_qest * DIV_W);

    assign w_take    = (r_s3_rest >= DIV_W);
    assign n_s4_quot = r_s3_qest + WORD_W'(w_take);
    assign n_s4_rem  = w_take ? (r_s3_rest - DIV_W) : r_s3_rest;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
        end else if (i_en) begin
            r_s1_vld <= i_valid;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
            r_s4_vld <= r_s3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_hh   <= n_s1_hh;
            r_s1_hl   <= n_s1_hl;
            r_s1_lh   <= n_s1_lh;
            r_s1_ll   <= n_s1_ll[TIME_W-1:WORD_W];
            r_s1_lo   <= w_num_lo;
            r_s1_side <= i_side;
            r_s2_qest <= n_s2_qest;
            r_s2_lo   <= r_s1_lo;
            r_s2_side <= r_s1_side;
            r_s3_qest <= r_s2_qest;
            r_s3_rest <= n_s3_rest;
            r_s3_side <= r_s2_side;
            r_s4_quot <= n_s4_quot;
            r_s4_rem  <= n_s4_rem[RW-1:0];
            r_s4_side <= r_s3_side;
        end
    end

    assign o_valid = r_s4_vld;
    assign o_quot  = r_s4_quot;
    assign o_rem   = r_s4_rem;
    assign o_side  = r_s4_side;

endmodule
`default_nettype wire

### rtl/rhg_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// RTP header generator front end
// Picks the timestamp source and rescales it to the RTP clock:
// t / F, then q * rate and r * rate, then (r * rate) / F, then the sum.
// ----------------------------------------------------------------------------
module rhg_front
    import rhg_pkg::*;
#(
    parameter int unsigned TICK_FREQ = TICK_FREQ_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire logic              i_pts_prog_valid,
    input  wire logic [TIME_W-1:0] i_pts_prog_time,
    input  wire logic              i_pts_sys_valid,
    input  wire logic [TIME_W-1:0] i_pts_sys_time,
    input  wire logic              i_cr_prog_valid,
    input  wire logic [TIME_W-1:0] i_cr_prog_time,
    input  wire logic              i_cr_sys_valid,
    input  wire logic [TIME_W-1:0] i_cr_sys_time,
    input  wire t_cfg              i_cfg,
    output logic                   o_valid,
    output logic [WORD_W-1:0]      o_ts
);

    localparam int unsigned REM_W = $clog2(TICK_FREQ);

    logic [TIME_W-1:0]       w_time;
    logic                    w_d1_vld;
    logic [WORD_W-1:0]       w_d1_quot;
    logic [REM_W-1:0]        w_d1_rem;
    logic [WORD_W-1:0]       n_m_qr;
    logic [REM_W+WORD_W-1:0] n_m_rr;
    logic                    r_m_vld;
    logic [WORD_W-1:0]       r_m_qr;
    logic [REM_W+WORD_W-1:0] r_m_rr;
    logic                    w_d2_vld;
    logic [WORD_W-1:0]       w_d2_quot;
    logic [WORD_W-1:0]       w_d2_side;
    logic                    r_f_vld;
    logic [WORD_W-1:0]       r_f_ts;

    always_comb begin
        if (i_cfg.sync_to_clock_ref) begin
            if (i_cr_prog_valid) begin
                w_time = i_cr_prog_time;
            end else if (i_cr_sys_valid) begin
                w_time = i_cr_sys_time;
            end else begin
                w_time = '0;
            end
        end else begin
            if (i_pts_prog_valid) begin
                w_time = i_pts_prog_time;
            end else if (i_pts_sys_valid) begin
                w_time = i_pts_sys_time;
            end else begin
                w_time = '0;
            end
        end
    end

    rhg_cdiv #(
        .DIVISOR (TICK_FREQ),
        .RW      (REM_W),
        .SW      (1)
    ) u_div_time (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (i_valid),
        .i_num   (w_time),
        .i_side  (1'b0),
        .o_valid (w_d1_vld),
        .o_quot  (w_d1_quot),
        .o_rem   (w_d1_rem),
        .o_side  ()
    );

    // only the low word of q matters modulo 2^32
    assign n_m_qr = WORD_W'(w_d1_quot * i_cfg.rtp_clock_rate);
    assign n_m_rr = (REM_W+WORD_W)'(w_d1_rem) * (REM_W+WORD_W)'(i_cfg.rtp_clock_rate);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
        end else if (i_en) begin
            r_m_vld <= w_d1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m_qr <= n_m_qr;
            r_m_rr <= n_m_rr;
        end
    end

    // r * rate < F * 2^32, so the quotient fits one word
    rhg_cdiv #(
        .DIVISOR (TICK_FREQ),
        .RW      (REM_W),
        .SW      (WORD_W)
    ) u_div_frac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r_m_vld),
        .i_num   (TIME_W'(r_m_rr)),
        .i_side  (r_m_qr),
        .o_valid (w_d2_vld),
        .o_quot  (w_d2_quot),
        .o_rem   (),
        .o_side  (w_d2_side)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else if (i_en) begin
            r_f_vld <= w_d2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_f_ts <= w_d2_side + w_d2_quot;
        end
    end

    assign o_valid = r_f_vld;
    assign o_ts    = r_f_ts;

endmodule
`default_nettype wire

### rtl/rhg_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Timestamp queue
// Small FIFO between the rescaling pipeline and the header word sequencer.
// ----------------------------------------------------------------------------
module rhg_queue
    import rhg_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEF,
    parameter int unsigned WIDTH = WORD_W
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output t_q_stat               o_stat
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic [PTR_W-1:0] n_wr;
    logic [PTR_W-1:0] n_rd;

    assign n_wr = (r_wr == PTR_LAST) ? '0 : r_wr + PTR_W'(1);
    assign n_rd = (r_rd == PTR_LAST) ? '0 : r_rd + PTR_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= n_wr;
            end
            if (i_pop) begin
                r_rd <= n_rd;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_data       = r_mem[r_rd];
    assign o_stat.empty = (r_cnt == '0);
    assign o_stat.full  = (r_cnt == CNT_FULL);

endmodule
`default_nettype wire

### rtl/rhg_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// RTP header word sequencer
// Emits the header words of the queue head one per cycle unless stalled,
// and keeps the sequence number.
// ----------------------------------------------------------------------------
module rhg_back
    import rhg_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cfg              i_cfg,
    input  wire logic [WORD_W-1:0] i_q_data,
    input  wire t_q_stat           i_q_stat,
    output logic                   o_pop,
    output logic                   o_valid,
    output logic [WORD_W-1:0]      o_word,
    output logic                   o_last,
    input  wire logic              i_stall
);

    localparam logic [1:0] WORD_HDR  = 2'd0;
    localparam logic [1:0] WORD_TS   = 2'd1;
    localparam logic [1:0] WORD_SSRC = 2'd2;
    localparam logic [1:0] WORD_MPA  = 2'd3;

    logic [1:0]        r_idx;
    logic [SEQ_W-1:0]  r_seq;
    logic              r_valid;
    logic [WORD_W-1:0] r_word;
    logic              r_last;
    logic              w_load;
    logic              n_last;
    logic [WORD_W-1:0] n_word;

    assign w_load = (!r_valid || !i_stall) && !i_q_stat.empty;
    assign n_last = (r_idx == (i_cfg.mpa_header_enable ? WORD_MPA : WORD_SSRC));

    always_comb begin
        case (r_idx)
            WORD_HDR: begin
                // V=2, P=0, X=0, CC=0, M=0
                n_word = {RTP_VERSION, 1'b0, 1'b0, 4'd0, 1'b0,
                          i_cfg.payload_type, r_seq};
            end
            WORD_TS: begin
                n_word = i_q_data;
            end
            default: begin
                n_word = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= WORD_HDR;
            r_seq   <= '0;
        end else if (w_load) begin
            r_valid <= 1'b1;
            if (n_last) begin
                r_idx <= WORD_HDR;
                r_seq <= r_seq + SEQ_W'(1);
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_word <= n_word;
            r_last <= n_last;
        end
    end

    assign o_pop   = w_load && n_last;
    assign o_valid = r_valid;
    assign o_word  = r_word;
    assign o_last  = r_last;

endmodule
`default_nettype wire
